>>> rtl/crps_pkg.sv
package crps_pkg;

  localparam int SEG         = 16;
  localparam int STORE_DEPTH = 512;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int SW     = $clog2(SEG + 1);
  localparam int CW     = 21;
  localparam int ACC_W  = 48;

  localparam logic signed [ACC_W-1:0] K_S   = ACC_W'(SEG);
  localparam logic signed [ACC_W-1:0] K_S2  = ACC_W'(SEG * SEG);
  localparam logic signed [ACC_W-1:0] K_S3  = ACC_W'(SEG * SEG * SEG);
  localparam logic signed [ACC_W-1:0] K_HI  = ACC_W'(32768 * 2 * SEG * SEG * SEG);

  // floor(rem / (2*SEG^3)) as (rem * DIV_M) >> DIV_SH, exact for rem < 2^REM_W
  localparam int DIV_L  = $clog2(2 * SEG * SEG * SEG);
  localparam int REM_W  = 16 + DIV_L;
  localparam int DIV_SH = REM_W + DIV_L;
  localparam logic [REM_W:0] DIV_M =
    (REM_W+1)'(((64'd1 << DIV_SH) + 64'(2 * SEG * SEG * SEG) - 64'd1)
               / 64'(2 * SEG * SEG * SEG));

  localparam logic OP_POINT    = 1'b0;
  localparam logic OP_QUERY    = 1'b1;
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic               on_path;
    logic               final_result;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } pt_t;

  typedef struct packed {
    logic query;
    logic clear;
    logic seg_a;
    logic seg_b;
    logic emit_pt;
    pt_t  p;
    pt_t  w0;
    pt_t  w1;
    pt_t  w2;
  } cmd_t;

endpackage

>>> rtl/catmull_rom_path_sampler.sv
// Catmull-Rom path sampler. Control points and on-path queries enter through a
// queue-style port; results leave through one. A point after a closed path
// starts a new path and clears the sample store. Each point from the third on
// emits SEG spline samples (end neighbors clamped), and a point marked last
// also emits the closing segment and itself; final_result flags the last
// result of each item. Samples beyond STORE_DEPTH are dropped without output.
// A sample passes through the shared sample datapath: three multiply steps, a
// saturate step, a reciprocal-multiply quotient step and the emit step, which
// waits while the result port stalls; each segment adds a setup step. A query
// scans the stored samples one by one through the sample memory's read port
// (read, square, compare), stopping at the first hit. The user must write
// half_width through cfg_* while the block is idle; the block does not check.
module catmull_rom_path_sampler
  import crps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  in_item_t    in_item,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] half_width_r;
  logic        cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t        cmd_in, cmd_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= 16'd640;
    end else if (cfg_valid) begin
      half_width_r <= cfg_data;
    end
  end

  crps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in),
    .cmd_full (cmd_full)
  );

  crps_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  crps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_empty  (cmd_empty),
    .cmd        (cmd_out),
    .cmd_pop    (cmd_pop),
    .half_width (half_width_r),
    .out_empty  (out_empty),
    .out_item   (out_item),
    .out_pop    (out_pop)
  );

endmodule

>>> rtl/crps_ram.sv
module crps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/crps_cmdq.sv
module crps_cmdq
  import crps_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign dout  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push && !full) - 2'(pop && !empty);
    end
  end

endmodule

>>> rtl/crps_front.sv
module crps_front
  import crps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_item,
  output logic     in_full,
  output logic     cmd_push,
  output cmd_t     cmd_data,
  input  logic     cmd_full
);

  pt_t        w0_r, w1_r, w2_r;
  logic [1:0] seen_r;
  logic       closed_r;
  pt_t        p;
  logic       acc;

  assign in_full  = cmd_full;
  assign acc      = in_push && !cmd_full;
  assign cmd_push = acc;
  assign p.x      = in_item.point_x;
  assign p.y      = in_item.point_y;

  always_comb begin
    cmd_data         = '0;
    cmd_data.p       = p;
    cmd_data.w0      = w0_r;
    cmd_data.w1      = w1_r;
    cmd_data.w2      = w2_r;
    cmd_data.query   = in_item.op == OP_QUERY;
    if (in_item.op == OP_POINT) begin
      if (closed_r) begin
        cmd_data.clear   = 1'b1;
        cmd_data.emit_pt = in_item.last_point;
      end else begin
        cmd_data.seg_a   = seen_r >= 2'd2;
        cmd_data.seg_b   = in_item.last_point;
        cmd_data.emit_pt = in_item.last_point;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w0_r     <= '0;
      w1_r     <= '0;
      w2_r     <= '0;
      seen_r   <= 2'd0;
      closed_r <= 1'b1;
    end else if (acc && in_item.op == OP_POINT) begin
      if (closed_r) begin
        w0_r     <= p;
        w1_r     <= p;
        w2_r     <= p;
        seen_r   <= 2'd1;
        closed_r <= in_item.last_point;
      end else begin
        w0_r <= w1_r;
        w1_r <= w2_r;
        w2_r <= p;
        if (seen_r != 2'd3) seen_r <= seen_r + 2'd1;
        closed_r <= in_item.last_point;
      end
    end
  end

endmodule

>>> rtl/crps_back.sv
module crps_back
  import crps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_empty,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  input  logic [15:0] half_width,
  output logic        out_empty,
  output out_item_t   out_item,
  input  logic        out_pop
);

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_JOB  = 12'b000000000010,
    ST_M1   = 12'b000000000100,
    ST_M2   = 12'b000000001000,
    ST_M3   = 12'b000000010000,
    ST_SAT  = 12'b000000100000,
    ST_DIV  = 12'b000001000000,
    ST_EMIT = 12'b000010000000,
    ST_QRD  = 12'b000100000000,
    ST_QSQ  = 12'b001000000000,
    ST_QCMP = 12'b010000000000,
    ST_QOUT = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  cmd_t   cmd_r;
  logic   seg_a_r, seg_b_r, pt_r, seg_busy_r;
  logic [SW-1:0] s_r;
  logic signed [CW-1:0]    ca_r [2], cb_r [2], cc_r [2], cd_r [2];
  logic signed [CW-1:0]    nca [2], ncb [2], ncc [2], ncd [2];
  logic signed [ACC_W-1:0] acc_r [2];
  logic        [ACC_W-1:0] rem_r [2];
  logic        [15:0]      satv_r [2], res_r [2];
  logic                    sat_r [2];
  logic        [2*REM_W:0] qprod [2];
  logic        [15:0]      qv [2];
  logic [CNT_W-1:0] cnt_r, sidx_r;
  logic [31:0]      hw2_r;
  logic [33:0]      sq_r [2];
  logic             hit_r;
  out_item_t        out_r;
  logic             ovalid_r, ovalid_nxt;

  logic              slot_free, cnt_full, more_planned, last_slot, hit_now, scan_end;
  logic signed [SW:0] s_sg;
  logic [34:0]       sum_sq;
  pt_t               sa, sb, sc, sd;
  logic              ram_we;
  logic [31:0]       ram_rdata;
  logic signed [15:0] rd_c [2];
  logic signed [16:0] dd [2];

  function automatic logic signed [15:0] crd(pt_t p, int l);
    return (l == 1) ? p.y : p.x;
  endfunction

  assign slot_free = !ovalid_r || out_pop;
  assign cnt_full  = cnt_r == CNT_W'(STORE_DEPTH);
  assign last_slot = cnt_r == CNT_W'(STORE_DEPTH - 1);
  assign s_sg      = $signed({1'b0, s_r});
  assign more_planned = (seg_busy_r && s_r != SW'(SEG - 1)) || seg_a_r || seg_b_r || pt_r;
  assign sum_sq    = {1'b0, sq_r[0]} + {1'b0, sq_r[1]};
  assign hit_now   = sum_sq < {3'b000, hw2_r};
  assign scan_end  = CNT_W'(sidx_r + 1'b1) == cnt_r;
  assign out_empty = !ovalid_r;
  assign out_item  = out_r;
  assign cmd_pop   = (state_r == ST_IDLE) && !cmd_empty;
  assign ram_we    = (state_r == ST_EMIT) && slot_free;
  assign rd_c[0]   = ram_rdata[15:0];
  assign rd_c[1]   = ram_rdata[31:16];

  assign sa = seg_a_r ? cmd_r.w0 : cmd_r.w1;
  assign sb = seg_a_r ? cmd_r.w1 : cmd_r.w2;
  assign sc = seg_a_r ? cmd_r.w2 : cmd_r.p;
  assign sd = cmd_r.p;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      nca[l] = CW'(crd(sb, l)) <<< 1;
      ncb[l] = CW'(crd(sc, l)) - CW'(crd(sa, l));
      ncc[l] = (CW'(crd(sa, l)) <<< 1) - CW'(crd(sb, l)) * CW'(5)
               + (CW'(crd(sc, l)) <<< 2) - CW'(crd(sd, l));
      ncd[l] = CW'(crd(sb, l)) * CW'(3) - CW'(crd(sa, l))
               - CW'(crd(sc, l)) * CW'(3) + CW'(crd(sd, l));
      qprod[l] = (2*REM_W+1)'(rem_r[l][REM_W-1:0]) * (2*REM_W+1)'(DIV_M);
      qv[l]    = qprod[l][DIV_SH +: 16];
      dd[l]  = 17'(crd(cmd_r.p, l)) - 17'(rd_c[l]);
    end
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (out_pop && ovalid_r) ovalid_nxt = 1'b0;
    if (slot_free && (state_r == ST_EMIT || state_r == ST_QOUT)) ovalid_nxt = 1'b1;
  end

  crps_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata ({res_r[1], res_r[0]}),
    .raddr (sidx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          if (!cmd.query) state_nxt = ST_JOB;
          else if (cnt_r == '0) state_nxt = ST_QOUT;
          else state_nxt = ST_QRD;
        end
      end
      ST_JOB: begin
        priority if (cnt_full) state_nxt = ST_IDLE;
        else if (seg_a_r || seg_b_r) state_nxt = ST_M1;
        else if (pt_r) state_nxt = ST_EMIT;
        else state_nxt = ST_IDLE;
      end
      ST_M1: state_nxt = ST_M2;
      ST_M2: state_nxt = ST_M3;
      ST_M3: state_nxt = ST_SAT;
      ST_SAT: state_nxt = ST_DIV;
      ST_DIV: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          priority if (last_slot) state_nxt = ST_IDLE;
          else if (seg_busy_r && s_r != SW'(SEG - 1)) state_nxt = ST_M1;
          else state_nxt = ST_JOB;
        end
      end
      ST_QRD: state_nxt = ST_QSQ;
      ST_QSQ: state_nxt = ST_QCMP;
      ST_QCMP: state_nxt = (hit_now || scan_end) ? ST_QOUT : ST_QRD;
      ST_QOUT: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ovalid_r   <= 1'b0;
      cnt_r      <= '0;
      seg_a_r    <= 1'b0;
      seg_b_r    <= 1'b0;
      pt_r       <= 1'b0;
      seg_busy_r <= 1'b0;
      hit_r      <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (!cmd_empty) begin
            cmd_r      <= cmd;
            seg_a_r    <= cmd.seg_a;
            seg_b_r    <= cmd.seg_b;
            pt_r       <= cmd.emit_pt;
            seg_busy_r <= 1'b0;
            hw2_r      <= 32'(half_width) * 32'(half_width);
            hit_r      <= 1'b0;
            sidx_r     <= '0;
            if (cmd.clear) cnt_r <= '0;
          end
        end
        ST_JOB: begin
          if (!cnt_full) begin
            if (seg_a_r || seg_b_r) begin
              for (int l = 0; l < 2; l++) begin
                ca_r[l] <= nca[l];
                cb_r[l] <= ncb[l];
                cc_r[l] <= ncc[l];
                cd_r[l] <= ncd[l];
              end
              s_r        <= '0;
              seg_busy_r <= 1'b1;
              if (seg_a_r) seg_a_r <= 1'b0;
              else seg_b_r <= 1'b0;
            end else if (pt_r) begin
              res_r[0]   <= cmd_r.p.x;
              res_r[1]   <= cmd_r.p.y;
              pt_r       <= 1'b0;
              seg_busy_r <= 1'b0;
            end
          end
        end
        ST_M1: begin
          for (int l = 0; l < 2; l++) begin
            acc_r[l] <= ACC_W'(cd_r[l]) * ACC_W'(s_sg) + ACC_W'(cc_r[l]) * K_S;
          end
        end
        ST_M2: begin
          for (int l = 0; l < 2; l++) begin
            acc_r[l] <= acc_r[l] * s_sg + ACC_W'(cb_r[l]) * K_S2;
          end
        end
        ST_M3: begin
          for (int l = 0; l < 2; l++) begin
            acc_r[l] <= acc_r[l] * s_sg + ACC_W'(ca_r[l]) * K_S3 + K_S3;
          end
        end
        ST_SAT: begin
          for (int l = 0; l < 2; l++) begin
            sat_r[l]  <= (acc_r[l] >= K_HI) || (acc_r[l] < -K_HI);
            satv_r[l] <= (acc_r[l] >= K_HI) ? 16'h7fff : 16'h8000;
            rem_r[l]  <= acc_r[l] + K_HI;
          end
        end
        ST_DIV: begin
          for (int l = 0; l < 2; l++) begin
            res_r[l] <= sat_r[l] ? satv_r[l] : (qv[l] ^ 16'h8000);
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_r.kind         <= KIND_SAMPLE;
            out_r.sample_x     <= res_r[0];
            out_r.sample_y     <= res_r[1];
            out_r.on_path      <= 1'b0;
            out_r.final_result <= last_slot || !more_planned;
            cnt_r              <= cnt_r + 1'b1;
            if (seg_busy_r && s_r != SW'(SEG - 1)) s_r <= s_r + 1'b1;
          end
        end
        ST_QRD: begin
        end
        ST_QSQ: begin
          for (int l = 0; l < 2; l++) begin
            sq_r[l] <= 34'(dd[l]) * 34'(dd[l]);
          end
        end
        ST_QCMP: begin
          if (hit_now) hit_r <= 1'b1;
          sidx_r <= sidx_r + 1'b1;
        end
        ST_QOUT: begin
          if (slot_free) begin
            out_r.kind         <= KIND_QUERY;
            out_r.sample_x     <= '0;
            out_r.sample_y     <= '0;
            out_r.on_path      <= hit_r;
            out_r.final_result <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
